FILE: rtl/ghc_pkg.sv
// Package: shared types, constants and base32 helpers for the geohash codec.
`default_nettype none
package ghc_pkg;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_NEIGH  = 2'd2,
    CMD_ALL    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_MOVE,
    ST_ENC,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, arm bisection on input point
    logic dec_step;  // decode one character
    logic move;      // form neighbor point, arm encoder
    logic enc_step;  // encode one character
    logic dir_next;  // advance neighbor direction
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic dec_done;
    logic enc_done;
    logic dir_last;
  } sts_t;

  function automatic logic [7:0] b32_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0: c = "0";  5'd1: c = "1";  5'd2: c = "2";  5'd3: c = "3";
      5'd4: c = "4";  5'd5: c = "5";  5'd6: c = "6";  5'd7: c = "7";
      5'd8: c = "8";  5'd9: c = "9";  5'd10: c = "b"; 5'd11: c = "c";
      5'd12: c = "d"; 5'd13: c = "e"; 5'd14: c = "f"; 5'd15: c = "g";
      5'd16: c = "h"; 5'd17: c = "j"; 5'd18: c = "k"; 5'd19: c = "m";
      5'd20: c = "n"; 5'd21: c = "p"; 5'd22: c = "q"; 5'd23: c = "r";
      5'd24: c = "s"; 5'd25: c = "t"; 5'd26: c = "u"; 5'd27: c = "v";
      5'd28: c = "w"; 5'd29: c = "x"; 5'd30: c = "y"; default: c = "z";
    endcase
    return c;
  endfunction

  // returns {valid, index}
  function automatic logic [5:0] b32_index(input logic [7:0] ch);
    logic [7:0] c;
    logic [5:0] r;
    c = (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
    r = 6'd0;
    for (int k = 0; k < 32; k++) begin
      if (b32_char(5'(k)) == c) r = {1'b1, 5'(k)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ghc_ctrl.sv
// Controller: command sequencing state machine for the geohash codec.
`default_nettype none
module ghc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ghc_pkg::ctl_t      ctl,
  input  wire ghc_pkg::sts_t sts
);

  ghc_pkg::state_t state, state_next;
  ghc_pkg::cmd_t   cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghc_pkg::ST_IDLE;
      cmd   <= ghc_pkg::CMD_ENCODE;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) cmd <= ghc_pkg::cmd_t'(in_cmd);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ghc_pkg::ST_IDLE:
        if (in_valid) begin
          if (ghc_pkg::cmd_t'(in_cmd) == ghc_pkg::CMD_ENCODE) state_next = ghc_pkg::ST_ENC;
          else state_next = ghc_pkg::ST_DEC;
        end
      ghc_pkg::ST_DEC:
        if (sts.dec_done) begin
          if (cmd == ghc_pkg::CMD_DECODE) state_next = ghc_pkg::ST_OUT;
          else state_next = ghc_pkg::ST_MOVE;
        end
      ghc_pkg::ST_MOVE: state_next = ghc_pkg::ST_ENC;
      ghc_pkg::ST_ENC:  if (sts.enc_done) state_next = ghc_pkg::ST_OUT;
      ghc_pkg::ST_OUT:
        if (out_ready) begin
          if (cmd == ghc_pkg::CMD_ALL && !sts.dir_last) state_next = ghc_pkg::ST_MOVE;
          else state_next = ghc_pkg::ST_IDLE;
        end
      default: state_next = ghc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl           = '0;
    unique case (state)
      ghc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.load    = in_valid;
      end
      ghc_pkg::ST_DEC:  ctl.dec_step = ~sts.dec_done;
      ghc_pkg::ST_MOVE: ctl.move = 1'b1;
      ghc_pkg::ST_ENC:  ctl.enc_step = ~sts.enc_done;
      ghc_pkg::ST_OUT: begin
        out_valid    = 1'b1;
        ctl.dir_next = out_ready && cmd == ghc_pkg::CMD_ALL;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst)
    (state == ghc_pkg::ST_OUT && !out_ready) |=> state == ghc_pkg::ST_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == ghc_pkg::ST_DEC || state == ghc_pkg::ST_ENC))
    else $error("accepted word not started");

endmodule
`default_nettype wire

FILE: rtl/ghc_dp.sv
// Datapath: bisection decoder, neighbor move and bisection encoder, one character a cycle.
`default_nettype none
module ghc_dp #(
  parameter int MAX_CHARS = 12
) (
  input  wire logic                clk,
  input  wire ghc_pkg::ctl_t       ctl,
  output ghc_pkg::sts_t            sts,
  input  wire logic [1:0]          cmd,
  input  wire logic signed [31:0]  lat_in,
  input  wire logic signed [31:0]  lon_in,
  input  wire logic [3:0]          hash_length,
  input  wire logic [47:0]         hash_chars_hi,
  input  wire logic [47:0]         hash_chars_lo,
  input  wire logic [2:0]          direction,
  output logic                     status,
  output logic [47:0]              hash_out_hi,
  output logic [47:0]              hash_out_lo,
  output logic signed [31:0]       center_lat,
  output logic signed [31:0]       center_lon,
  output logic [31:0]              lat_halfwidth,
  output logic [31:0]              lon_halfwidth,
  output logic                     last
);

  localparam logic [3:0] LenMax = 4'(MAX_CHARS);

  // Bounds are 34-bit signed to hold +2^31 and moved points.
  logic signed [33:0] lat_min, lat_max, lon_min, lon_max;
  logic signed [33:0] pt_lat, pt_lon;
  logic [95:0]        chars;
  logic [95:0]        hash_acc;
  logic [3:0]         len, cnt;
  logic               on_lon;
  logic               st;
  logic [2:0]         dir;
  logic               all_dirs;
  logic               decoded;   // output shows decoded cell

  // ---- one character of bisection, shared by encode and decode ----
  logic signed [33:0] n_lat_min, n_lat_max, n_lon_min, n_lon_max;
  logic [4:0]         bits;
  logic               n_on_lon;
  logic [5:0]         dv;
  logic [4:0]         want;

  assign dv   = ghc_pkg::b32_index(chars[95:88]);
  assign want = dv[4:0];

  always_comb begin
    logic signed [33:0] mid;
    logic               b;
    n_lat_min = lat_min; n_lat_max = lat_max;
    n_lon_min = lon_min; n_lon_max = lon_max;
    n_on_lon  = on_lon;
    bits      = '0;
    for (int k = 0; k < 5; k++) begin
      if (n_on_lon) begin
        mid = n_lon_min + ((n_lon_max - n_lon_min) >>> 1);
        b   = ctl.dec_step ? want[4-k] : (pt_lon > mid);
        if (b) n_lon_min = mid; else n_lon_max = mid;
      end else begin
        mid = n_lat_min + ((n_lat_max - n_lat_min) >>> 1);
        b   = ctl.dec_step ? want[4-k] : (pt_lat > mid);
        if (b) n_lat_min = mid; else n_lat_max = mid;
      end
      bits     = {bits[3:0], b};
      n_on_lon = ~n_on_lon;
    end
  end

  // neighbor point
  logic signed [33:0] hw_lat, hw_lon, c_lat, c_lon, m_lat, m_lon, w_lon;
  logic signed [1:0]  dl, dn;
  always_comb begin
    hw_lat = (lat_max - lat_min) >>> 1;
    hw_lon = (lon_max - lon_min) >>> 1;
    c_lat  = lat_min + hw_lat;
    c_lon  = lon_min + hw_lon;
    unique case (dir)
      3'd0: begin dl = 2'sd1;  dn = 2'sd0;  end
      3'd1: begin dl = 2'sd1;  dn = 2'sd1;  end
      3'd2: begin dl = 2'sd0;  dn = 2'sd1;  end
      3'd3: begin dl = -2'sd1; dn = 2'sd1;  end
      3'd4: begin dl = -2'sd1; dn = 2'sd0;  end
      3'd5: begin dl = -2'sd1; dn = -2'sd1; end
      3'd6: begin dl = 2'sd0;  dn = -2'sd1; end
      default: begin dl = 2'sd1; dn = -2'sd1; end
    endcase
    m_lat = (dl == 2'sd1) ? lat_max + hw_lat : (dl == -2'sd1) ? lat_min - hw_lat : c_lat;
    m_lon = (dn == 2'sd1) ? lon_max + hw_lon : (dn == -2'sd1) ? lon_min - hw_lon : c_lon;
    if (m_lat > 34'sh80000000 || m_lat < -34'sh80000000) begin
      m_lat = c_lat;
      m_lon = m_lon + 34'sh80000000;
    end
    w_lon = m_lon;
    if (m_lon < -34'sh80000000)     w_lon = m_lon + 34'sh100000000;
    else if (m_lon > 34'sh80000000) w_lon = m_lon - 34'sh100000000;
  end

  // decoded cell held across neighbor passes
  logic signed [33:0] d_lat_min, d_lat_max, d_lon_min, d_lon_max;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      len      <= (hash_length > LenMax) ? LenMax : hash_length;
      chars    <= {hash_chars_hi, hash_chars_lo};
      pt_lat   <= 34'(lat_in);
      pt_lon   <= 34'(lon_in);
      dir      <= (ghc_pkg::cmd_t'(cmd) == ghc_pkg::CMD_ALL) ? 3'd0 : direction;
      all_dirs <= (ghc_pkg::cmd_t'(cmd) == ghc_pkg::CMD_ALL);
      decoded  <= (ghc_pkg::cmd_t'(cmd) == ghc_pkg::CMD_DECODE);
      st       <= 1'b0;
      cnt      <= '0;
      hash_acc <= '0;
      on_lon   <= 1'b1;
      lat_min  <= -34'sh80000000; lat_max <= 34'sh80000000;
      lon_min  <= -34'sh80000000; lon_max <= 34'sh80000000;
    end else if (ctl.dec_step) begin
      cnt   <= cnt + 4'd1;
      chars <= {chars[87:0], 8'h00};
      if (!dv[5]) begin
        st  <= 1'b1;
        cnt <= len;
        lat_min <= -34'sh80000000; lat_max <= 34'sh80000000;
        lon_min <= -34'sh80000000; lon_max <= 34'sh80000000;
      end else begin
        lat_min <= n_lat_min; lat_max <= n_lat_max;
        lon_min <= n_lon_min; lon_max <= n_lon_max;
        on_lon  <= n_on_lon;
      end
    end else if (ctl.move) begin
      pt_lat    <= m_lat;
      pt_lon    <= w_lon;
      d_lat_min <= lat_min; d_lat_max <= lat_max;
      d_lon_min <= lon_min; d_lon_max <= lon_max;
      cnt       <= '0;
      hash_acc  <= '0;
      on_lon    <= 1'b1;
      lat_min   <= -34'sh80000000; lat_max <= 34'sh80000000;
      lon_min   <= -34'sh80000000; lon_max <= 34'sh80000000;
    end else if (ctl.enc_step) begin
      cnt      <= cnt + 4'd1;
      hash_acc <= hash_acc | ({88'd0, ghc_pkg::b32_char(bits)} << (7'd88 - {cnt, 3'b000}));
      lat_min <= n_lat_min; lat_max <= n_lat_max;
      lon_min <= n_lon_min; lon_max <= n_lon_max;
      on_lon  <= n_on_lon;
    end else if (ctl.dir_next) begin
      dir     <= dir + 3'd1;
      lat_min <= d_lat_min; lat_max <= d_lat_max;
      lon_min <= d_lon_min; lon_max <= d_lon_max;
    end
  end

  assign sts.dec_done = (cnt >= len);
  assign sts.enc_done = (cnt >= len);
  assign sts.dir_last = (dir == 3'd7);

  assign status        = st;
  assign hash_out_hi   = decoded ? 48'd0 : hash_acc[95:48];
  assign hash_out_lo   = decoded ? 48'd0 : hash_acc[47:0];
  assign center_lat    = decoded ? c_lat[31:0] : 32'sd0;
  assign center_lon    = decoded ? c_lon[31:0] : 32'sd0;
  assign lat_halfwidth = decoded ? hw_lat[31:0] : 32'd0;
  assign lon_halfwidth = decoded ? hw_lon[31:0] : 32'd0;
  assign last          = !all_dirs || (dir == 3'd7);

endmodule
`default_nettype wire

FILE: rtl/geohash_codec_neighbors_core.sv
// Top level: geohash encode, decode and neighbor core.
//
// channel | handshake           | fields
// in      | in_valid/in_ready   | cmd lat_in lon_in hash_length hash_chars_hi/lo direction
// out     | out_valid/out_ready | status hash_out_hi/lo center_lat/lon lat/lon_halfwidth last
//
// Sequence (after length saturation): encode and decode accept, bisect each character,
//   check done and output; neighbor decodes, moves, encodes, outputs; all eight decodes
//   once, then moves, encodes, outputs per direction. An invalid character stops decode early.
// One word is in flight at a time; the output word holds until out_ready.
// Reset (rst, synchronous) returns the controller to idle.
`default_nettype none
module geohash_codec_neighbors_core #(
  parameter int MAX_CHARS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [31:0] lat_in,
  input  wire logic signed [31:0] lon_in,
  input  wire logic [3:0]         hash_length,
  input  wire logic [47:0]        hash_chars_hi,
  input  wire logic [47:0]        hash_chars_lo,
  input  wire logic [2:0]         direction,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    status,
  output logic [47:0]             hash_out_hi,
  output logic [47:0]             hash_out_lo,
  output logic signed [31:0]      center_lat,
  output logic signed [31:0]      center_lon,
  output logic [31:0]             lat_halfwidth,
  output logic [31:0]             lon_halfwidth,
  output logic                    last
);

  ghc_pkg::ctl_t ctl;
  ghc_pkg::sts_t sts;

  ghc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_cmd(cmd),
    .out_valid, .out_ready, .ctl, .sts
  );

  ghc_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
    .clk, .ctl, .sts, .cmd, .lat_in, .lon_in, .hash_length,
    .hash_chars_hi, .hash_chars_lo, .direction,
    .status, .hash_out_hi, .hash_out_lo, .center_lat, .center_lon,
    .lat_halfwidth, .lon_halfwidth, .last
  );

endmodule
`default_nettype wire
